FILE: hw/rtl/glu_pkg.sv
// Package for the gcd/lcm unit: field widths, the default operand width
// and the sequencer's state and mode types. No dependencies.
`timescale 1ns / 1ps

package glu_pkg;

   // Fixed widths of the beat fields.
   localparam int unsigned OPERAND_FIELD_WIDTH = 32;
   localparam int unsigned GCD_WIDTH           = 32;
   localparam int unsigned LCM_WIDTH           = 64;

   localparam int unsigned REQ_DATA_WIDTH = 2 * OPERAND_FIELD_WIDTH;
   localparam int unsigned RSP_DATA_WIDTH = GCD_WIDTH + LCM_WIDTH;

   // Number of low operand bits actually used (4 to 32).
   localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   // What the running division is for.
   typedef enum logic {
      MODE_EUCLID,
      MODE_QUOT
   } mode_type;

endpackage

FILE: hw/rtl/gcd_lcm_unit.sv
// Top level of the gcd/lcm unit: sequencer around one shared restoring
// divider step, plus the lcm product register. Depends on glu_pkg.
`timescale 1ns / 1ps

// Usage.
// A request beat on req_* carries two unsigned operands; only their low
// OPERAND_WIDTH bits are used. The unit answers every request with exactly
// one response beat on rsp_*: the greatest common divisor, the least common
// multiple at full double width, and a flag in rsp_tuser that is set when
// either operand was zero (the lcm is then zero and the gcd is the other
// operand, or zero when both are).
// Sequence: one restoring divider step is done per cycle. Euclid's
// algorithm needs k remainder steps (at most 46 for 32-bit operands,
// counting the swap step when a < b), then one division a/gcd and the
// lcm product follow.
// req_tready is high only while the sequencer is idle; a new request may be
// taken while the previous response still sits in the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up; nothing is dropped.
// Reset (synchronous, active high) returns the sequencer to idle and clears
// the response valid; no result is pending afterwards.
module gcd_lcm_unit #(
   parameter int unsigned OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0 up: operand_a [31:0], operand_b [63:32].
   input  logic [glu_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0 up: gcd_value [31:0], lcm_value [95:32].
   output logic [glu_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // Fields from bit 0 up: zero_operand [0].
   output logic                               rsp_tuser
);
   import glu_pkg::*;

   localparam int unsigned W      = OPERAND_WIDTH;
   localparam int unsigned PROD_W = 2 * OPERAND_WIDTH;
   localparam int unsigned CNT_W  = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]      rem_ff, rem_in;   // partial remainder
   logic [W-1:0]      dvd_ff, dvd_in;   // dividend, becomes the quotient
   logic [W-1:0]      dvs_ff, dvs_in;   // divisor
   logic [W-1:0]      opa_ff, opa_in;
   logic [W-1:0]      opb_ff, opb_in;
   logic [W-1:0]      g_ff, g_in;
   logic              zero_ff, zero_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GCD_WIDTH-1:0] rsp_gcd_ff, rsp_gcd_in;
   logic [LCM_WIDTH-1:0] rsp_lcm_ff, rsp_lcm_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic          req_fire;
   logic          out_free;
   logic [W-1:0]  a_m, b_m;
   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          step_ge;
   logic [W-1:0]  rem_step;
   logic [W-1:0]  dvd_step;
   logic          last_step;

   assign a_m = req_tdata[W-1:0];
   assign b_m = req_tdata[OPERAND_FIELD_WIDTH+W-1:OPERAND_FIELD_WIDTH];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The shared unit: one restoring division step per cycle.
   assign shifted   = {rem_ff, dvd_ff[W-1]};
   assign diff      = shifted - {1'b0, dvs_ff};
   assign step_ge   = !diff[W];
   assign rem_step  = step_ge ? diff[W-1:0] : shifted[W-1:0];
   assign dvd_step  = {dvd_ff[W-2:0], step_ge};
   assign last_step = (cnt_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (b_m == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_step) begin
               if (mode_ff == MODE_QUOT) begin
                  state_in = ST_MUL;
               end else if (rem_step == '0 && zero_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and output register.
   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      g_in         = g_ff;
      zero_in      = zero_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_lcm_in   = rsp_lcm_ff;
      rsp_zero_in  = rsp_zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               opa_in  = a_m;
               opb_in  = b_m;
               zero_in = (a_m == '0) || (b_m == '0);
               g_in    = a_m;       // answer when b is zero
               prod_in = '0;
               mode_in = MODE_EUCLID;
               dvd_in  = a_m;
               dvs_in  = b_m;
               rem_in  = '0;
               cnt_in  = CNT_LAST;
            end
         end
         ST_DIV: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff - 1'b1;
            if (last_step && mode_ff == MODE_EUCLID) begin
               rem_in = '0;
               cnt_in = CNT_LAST;
               if (rem_step == '0) begin
                  // Divisor divides evenly: it is the gcd. Next divide a by it, unless an operand was zero.
                  g_in    = dvs_ff;
                  mode_in = MODE_QUOT;
                  dvd_in  = opa_ff;
               end else begin
                  dvd_in = dvs_ff;
                  dvs_in = rem_step;
               end
            end
         end
         ST_MUL: begin
            // dvd_ff holds a / gcd here.
            prod_in = PROD_W'(dvd_ff) * PROD_W'(opb_ff);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_gcd_in   = GCD_WIDTH'(g_ff);
               rsp_lcm_in   = LCM_WIDTH'(prod_ff);
               rsp_zero_in  = zero_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      g_ff        <= g_in;
      zero_ff     <= zero_in;
      prod_ff     <= prod_in;
      rsp_gcd_ff  <= rsp_gcd_in;
      rsp_lcm_ff  <= rsp_lcm_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_lcm_ff, rsp_gcd_ff};
   assign rsp_tuser  = rsp_zero_ff;

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dvs_ff != '0))
      else $error("divider running with zero divisor");

   // a / gcd is never zero when the product is formed.
   a_quot_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (dvd_ff != '0))
      else $error("zero quotient before lcm product");

   // A response only appears out of the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   // Without a zero operand both results are nonzero.
   a_nonzero_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_gcd_ff != '0 && rsp_lcm_ff != '0))
      else $error("zero result without a zero operand");

endmodule
